### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/asmlex_pkg.sv
// Shared types, codes and character classes for the assembler line lexer
package asmlex_pkg;

    // Token kinds on the result channel
    localparam logic [2:0] KIND_IDENT = 3'd0;
    localparam logic [2:0] KIND_DEC   = 3'd1;
    localparam logic [2:0] KIND_HEX   = 3'd2;
    localparam logic [2:0] KIND_PUNCT = 3'd3;
    localparam logic [2:0] KIND_EOL   = 3'd4;

    // Special characters
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_UNDER = 8'h5f;

    // Queue between front and back
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // One result item
    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] kind;
        logic       first;
        logic       last;
    } res_t;

    // All results caused by one input character (one or two)
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || (c == CHAR_UNDER);
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_NUL);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF);
    endfunction

endpackage

### rtl/asmlex_front.sv
// Front end: accepts characters, tracks lexer mode and builds result entries
module asmlex_front import asmlex_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  q_stat_t    q_stat,
    output logic       push,
    output entry_t     push_entry
);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_DEC   = 3'd2;
    localparam logic [2:0] MODE_AMP   = 3'd3;
    localparam logic [2:0] MODE_HEX   = 3'd4;

    // Outcome of lexing one character from idle
    typedef struct packed {
        logic       emit;
        res_t       res;
        logic [2:0] mode;
        logic [7:0] held;
        logic       first;
    } idle_t;

    logic [2:0] mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic       hfirst_reg, hfirst_next;

    logic       accept;
    logic       pre_v;
    res_t       pre;
    idle_t      idl;
    logic       use_idle;
    logic       cont;
    logic [2:0] run_kind;

    function automatic idle_t from_idle(input logic [7:0] c);
        idle_t r;
        r.emit  = 1'b0;
        r.res   = '{ch: c, kind: KIND_PUNCT, first: 1'b1, last: 1'b1};
        r.mode  = MODE_IDLE;
        r.held  = 8'd0;
        r.first = 1'b0;
        if (is_eol(c)) begin
            r.emit = 1'b1;
            r.res  = '{ch: 8'd0, kind: KIND_EOL, first: 1'b1, last: 1'b1};
        end else if (is_blank(c)) begin
            r.emit = 1'b0;
        end else if (is_digit(c)) begin
            r.mode  = MODE_DEC;
            r.held  = c;
            r.first = 1'b1;
        end else if (is_alpha(c)) begin
            r.mode  = MODE_IDENT;
            r.held  = c;
            r.first = 1'b1;
        end else if (c == CHAR_AMP) begin
            r.mode = MODE_AMP;
        end else begin
            r.emit = 1'b1;
        end
        return r;
    endfunction

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign idl     = from_idle(s_in_char);

    // Continuation test and kind for the open token
    always_comb begin
        case (mode_reg)
            MODE_IDENT: begin
                cont     = is_digit(s_in_char) || is_alpha(s_in_char);
                run_kind = KIND_IDENT;
            end
            MODE_DEC: begin
                cont     = is_digit(s_in_char);
                run_kind = KIND_DEC;
            end
            MODE_HEX: begin
                cont     = is_xdigit(s_in_char);
                run_kind = KIND_HEX;
            end
            default: begin
                cont     = 1'b0;
                run_kind = KIND_IDENT;
            end
        endcase
    end

    // Next mode and the result that precedes any idle-path result
    always_comb begin
        pre_v       = 1'b0;
        pre         = '{ch: held_reg, kind: run_kind, first: hfirst_reg, last: 1'b1};
        use_idle    = 1'b0;
        mode_next   = mode_reg;
        held_next   = held_reg;
        hfirst_next = hfirst_reg;
        case (mode_reg)
            MODE_IDENT, MODE_DEC, MODE_HEX: begin
                pre_v = 1'b1;
                if (cont) begin
                    pre.last    = 1'b0;
                    held_next   = s_in_char;
                    hfirst_next = 1'b0;
                end else begin
                    use_idle = 1'b1;
                end
            end
            MODE_AMP: begin
                if (is_xdigit(s_in_char)) begin
                    mode_next   = MODE_HEX;
                    held_next   = s_in_char;
                    hfirst_next = 1'b1;
                end else begin
                    pre_v    = 1'b1;
                    pre      = '{ch: CHAR_AMP, kind: KIND_PUNCT, first: 1'b1, last: 1'b1};
                    use_idle = 1'b1;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase
        if (use_idle) begin
            mode_next   = idl.mode;
            held_next   = idl.held;
            hfirst_next = idl.first;
        end
    end

    // Pack results into one queue entry
    always_comb begin
        push_entry.two = pre_v && use_idle && idl.emit;
        push_entry.r0  = pre_v ? pre : idl.res;
        push_entry.r1  = idl.res;
        push           = accept && (pre_v || (use_idle && idl.emit));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= 8'd0;
            hfirst_reg <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            hfirst_reg <= hfirst_next;
        end
    end

endmodule

### rtl/asmlex_queue.sv
// Small queue of result entries between front and back
module asmlex_queue import asmlex_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t q_stat
);

    entry_t           mem [QDepth];
    logic [QAw-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAw:0]     count_reg, count_next;

    assign q_stat.full  = (count_reg == (QAw+1)'(QDepth));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/asmlex_back.sv
// Back end: splits queue entries into single results in an output register
module asmlex_back import asmlex_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  entry_t     head,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic [2:0] m_token_kind,
    output logic       m_token_first,
    output logic       m_token_last,
    output logic       m_run_last
);

    logic       valid_reg;
    logic       sel_reg;
    res_t       res_reg;
    logic       run_last_reg;
    logic       load;
    logic       is_end;
    res_t       cur;

    assign load   = !q_stat.empty && (!valid_reg || m_ready);
    assign cur    = sel_reg ? head.r1 : head.r0;
    assign is_end = !head.two || sel_reg;
    assign pop    = load && is_end;

    assign m_valid       = valid_reg;
    assign m_out_char    = res_reg.ch;
    assign m_token_kind  = res_reg.kind;
    assign m_token_first = res_reg.first;
    assign m_token_last  = res_reg.last;
    assign m_run_last    = run_last_reg;

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg      <= cur;
            run_last_reg <= is_end;
        end
    end

    // Output valid and position inside the current entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                sel_reg   <= !is_end;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/assembler_line_lexer.sv
// Assembler line lexer: top level joining front end, queue and back end
//
// Input channel s_valid/s_ready/s_in_char takes one source byte per transfer.
// Result channel m_valid/m_ready carries one token character per transfer,
// with m_token_kind (identifier, decimal, hex, punctuation, end of line),
// first/last marks, and m_run_last on the last result of an input byte.
// A multi-character token's character is held until the next byte shows
// whether it ends the token, so a byte yields zero, one or two results.
// A byte's entry is written to the queue at its transfer edge and then loaded
// into the output register once that register is free; a second result of
// the same byte follows once the first has been taken.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver does not stall; a byte yielding two results holds the output
// register for both, and the queue of 4 entries absorbs such bursts before s_ready drops.
// Reset (aresetn low, synchronous) returns the lexer to idle and empties the
// queue and the output register. When the receiver stalls, the output holds,
// the queue fills and s_ready falls once it is full.
module assembler_line_lexer import asmlex_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic [2:0] m_token_kind,
    output logic       m_token_first,
    output logic       m_token_last,
    output logic       m_run_last
);

    logic    push;
    logic    pop;
    entry_t  push_entry;
    entry_t  head;
    q_stat_t q_stat;

    asmlex_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    asmlex_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    asmlex_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_token_kind  (m_token_kind),
        .m_token_first (m_token_first),
        .m_token_last  (m_token_last),
        .m_run_last    (m_run_last)
    );

endmodule

### rtl/asmlex_checker.sv
// Port-level checks on the lexer's result channel, bound to the top level
`include "assert_macros.svh"

module asmlex_checker import asmlex_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic [2:0] m_token_kind,
    input logic       m_token_first,
    input logic       m_token_last,
    input logic       m_run_last
);

    // A stalled result stays offered
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")

    // End of line is a lone zero result closing its input byte
    `ASSERT_IMPLY(a_eol_shape, aclk, aresetn, m_valid && (m_token_kind == KIND_EOL), m_token_first && m_token_last && (m_out_char == 8'd0) && m_run_last, "bad end of line")

    // Punctuation is always a one-character token
    `ASSERT_IMPLY(a_punct_single, aclk, aresetn, m_valid && (m_token_kind == KIND_PUNCT), m_token_first && m_token_last, "punctuation not single")

    // No kind code beyond end of line
    `ASSERT_IMPLY(a_kind_range, aclk, aresetn, m_valid, (m_token_kind == KIND_IDENT) || (m_token_kind == KIND_DEC) || (m_token_kind == KIND_HEX) || (m_token_kind == KIND_PUNCT) || (m_token_kind == KIND_EOL), "bad token kind")

endmodule

bind assembler_line_lexer asmlex_checker u_asmlex_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_char    (m_out_char),
    .m_token_kind  (m_token_kind),
    .m_token_first (m_token_first),
    .m_token_last  (m_token_last),
    .m_run_last    (m_run_last)
);
